>>> sv/pocp_pkg.sv
// Package with shared types, constants and the filter coefficient table of the oximeter chain.
package pocp_pkg;

	localparam int RING_DEPTH_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int WORD_W          = 16;
	localparam int ACC_W           = 36;
	localparam int TAP_W           = 15;
	localparam int NUM_TAPS        = 12;
	localparam int CENTER_TAP      = 11;
	localparam int FIR_SPAN        = 22;
	localparam int PADDR_W         = 5;

	localparam logic [11:0] TARGET_HIGH_RST = 12'd3500;
	localparam logic [11:0] TARGET_LOW_RST  = 12'd3000;
	localparam logic [12:0] COARSE_HIGH_RST = 13'd4096;
	localparam logic [11:0] COARSE_LOW_RST  = 12'd2700;
	localparam logic [15:0] RISE_RST        = 16'd1000;
	localparam logic [15:0] FALL_RST        = 16'hFF38;
	localparam logic [7:0]  DEBOUNCE_RST    = 8'd120;
	localparam logic [3:0]  BEATS_RST       = 4'd3;
	localparam logic [11:0] OFFSET_RST      = 12'd2000;
	localparam logic [11:0] DRIVE_IR_RST    = 12'd1300;
	localparam logic [11:0] DRIVE_VIS_RST   = 12'd1450;
	localparam logic [11:0] OFFSET_MIN      = 12'd100;
	localparam logic [11:0] LEVEL_MAX       = 12'd4095;
	localparam logic [15:0] RAIL_LOW        = 16'd100;
	localparam int          DC_SHIFT        = 9;
	localparam int          FIR_SHIFT       = 15;
	localparam int          SQ_SHIFT        = 10;

	typedef enum logic [2:0] {
		REG_TARGET_HIGH = 3'd0,
		REG_TARGET_LOW  = 3'd1,
		REG_COARSE_HIGH = 3'd2,
		REG_COARSE_LOW  = 3'd3,
		REG_RISE        = 3'd4,
		REG_FALL        = 3'd5,
		REG_DEBOUNCE    = 3'd6,
		REG_BEATS       = 3'd7
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_FIR  = 7'b0000010,
		ST_DC   = 7'b0000100,
		ST_AC   = 7'b0001000,
		ST_SQ   = 7'b0010000,
		ST_UPD  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	function automatic logic [TAP_W-1:0] tap_coef(input logic [3:0] k);
		logic [TAP_W-1:0] c;
		case (k)
			4'd0:    c = 15'd688;
			4'd1:    c = 15'd1283;
			4'd2:    c = 15'd2316;
			4'd3:    c = 15'd3709;
			4'd4:    c = 15'd5439;
			4'd5:    c = 15'd7431;
			4'd6:    c = 15'd9561;
			4'd7:    c = 15'd11666;
			4'd8:    c = 15'd13563;
			4'd9:    c = 15'd15074;
			4'd10:   c = 15'd16047;
			4'd11:   c = 15'd16384;
			default: c = 15'd0;
		endcase
		return c;
	endfunction

endpackage

>>> sv/pocp_in_if.sv
// Input channel interface: one photodiode sample word per handshake.
interface pocp_in_if #(
	parameter int SAMPLE_BITS = pocp_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   channel;
	logic [SAMPLE_BITS-1:0] first_stage_sample;
	logic [SAMPLE_BITS-1:0] second_stage_sample;

	modport source (output valid, output channel, output first_stage_sample,
		output second_stage_sample, input ready);
	modport sink (input valid, input channel, input first_stage_sample,
		input second_stage_sample, output ready);
endinterface

>>> sv/pocp_out_if.sv
// Result channel interface: one processed result word per handshake.
interface pocp_out_if;
	logic        valid;
	logic        ready;
	logic        channel_out;
	logic [11:0] led_level;
	logic [11:0] amp_offset;
	logic [15:0] ac_signal;
	logic        pulse_on;
	logic        edge_seen;
	logic        window_valid;
	logic [15:0] window_samples;
	logic [31:0] window_ir_energy;
	logic [31:0] window_vis_energy;

	modport source (output valid, output channel_out, output led_level, output amp_offset,
		output ac_signal, output pulse_on, output edge_seen, output window_valid,
		output window_samples, output window_ir_energy, output window_vis_energy,
		input ready);
	modport sink (input valid, input channel_out, input led_level, input amp_offset,
		input ac_signal, input pulse_on, input edge_seen, input window_valid,
		input window_samples, input window_ir_energy, input window_vis_energy,
		output ready);
endinterface

>>> sv/pocp_ring.sv
// Two-channel sample ring memory with one write port, two registered read ports and valid bits.
module pocp_ring #(
	parameter int RING_DEPTH = pocp_pkg::RING_DEPTH_DEF,
	localparam int AW = $clog2(RING_DEPTH) + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [pocp_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [pocp_pkg::WORD_W-1:0] rdata_a,
	output logic [pocp_pkg::WORD_W-1:0] rdata_b
);
	localparam int N = 2 * RING_DEPTH;

	logic [pocp_pkg::WORD_W-1:0] mem_q [N];
	logic [N-1:0]                vld_q;
	logic [pocp_pkg::WORD_W-1:0] ra_q, rb_q;
	logic                        va_q, vb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_q <= mem_q[raddr_a];
		rb_q <= mem_q[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			va_q <= vld_q[raddr_a];
			vb_q <= vld_q[raddr_b];
		end
	end

	// Entries never written since reset read as zero.
	assign rdata_a = va_q ? ra_q : '0;
	assign rdata_b = vb_q ? rb_q : '0;
endmodule

>>> sv/pulse_oximeter_channel_processor_top.sv
// Top level of the pulse oximeter channel processor with sequencer, datapath and registers.
// Each accepted sample word is processed by a small sequencer around one shared multiplier.
// The word is written into its channel's ring in the accept cycle. Twelve ring read steps then feed
// the symmetric 23-tap filter through the multiplier. The filter pass includes the read and
// product registers. The DC tracker, the AC subtraction, the square (on the same multiplier)
// and the state update then follow in that order. The result word is presented after the state
// update and is held until the sink takes it. The input is ready only while the sequencer is
// idle, so a new word is not accepted until the sink has taken the result of the last one.
// Configuration is through the APB port at byte address 4*i for register i. pready is always
// high, and reads return the register contents.
module pulse_oximeter_channel_processor_top #(
	parameter int RING_DEPTH  = pocp_pkg::RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = pocp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pocp_in_if.sink                       smp,
	pocp_out_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pocp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int PW = $clog2(RING_DEPTH);
	localparam int AW = PW + 1;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	// Configuration registers.
	logic [11:0]        target_high_q, target_low_q, coarse_low_q;
	logic [12:0]        coarse_high_q;
	logic signed [15:0] rise_q, fall_q;
	logic [7:0]         debounce_q;
	logic [3:0]         beats_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_high_q <= pocp_pkg::TARGET_HIGH_RST;
			target_low_q  <= pocp_pkg::TARGET_LOW_RST;
			coarse_high_q <= pocp_pkg::COARSE_HIGH_RST;
			coarse_low_q  <= pocp_pkg::COARSE_LOW_RST;
			rise_q        <= pocp_pkg::RISE_RST;
			fall_q        <= pocp_pkg::FALL_RST;
			debounce_q    <= pocp_pkg::DEBOUNCE_RST;
			beats_q       <= pocp_pkg::BEATS_RST;
		end else if (psel && penable && pwrite) begin
			case (pocp_pkg::reg_idx_t'(paddr[4:2]))
				pocp_pkg::REG_TARGET_HIGH: target_high_q <= pwdata[11:0];
				pocp_pkg::REG_TARGET_LOW:  target_low_q  <= pwdata[11:0];
				pocp_pkg::REG_COARSE_HIGH: coarse_high_q <= pwdata[12:0];
				pocp_pkg::REG_COARSE_LOW:  coarse_low_q  <= pwdata[11:0];
				pocp_pkg::REG_RISE:        rise_q        <= pwdata[15:0];
				pocp_pkg::REG_FALL:        fall_q        <= pwdata[15:0];
				pocp_pkg::REG_DEBOUNCE:    debounce_q    <= pwdata[7:0];
				pocp_pkg::REG_BEATS:       beats_q       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pocp_pkg::reg_idx_t'(paddr[4:2]))
			pocp_pkg::REG_TARGET_HIGH: prdata = {20'd0, target_high_q};
			pocp_pkg::REG_TARGET_LOW:  prdata = {20'd0, target_low_q};
			pocp_pkg::REG_COARSE_HIGH: prdata = {19'd0, coarse_high_q};
			pocp_pkg::REG_COARSE_LOW:  prdata = {20'd0, coarse_low_q};
			pocp_pkg::REG_RISE:        prdata = {16'd0, rise_q};
			pocp_pkg::REG_FALL:        prdata = {16'd0, fall_q};
			pocp_pkg::REG_DEBOUNCE:    prdata = {24'd0, debounce_q};
			pocp_pkg::REG_BEATS:       prdata = {28'd0, beats_q};
			default:                   prdata = '0;
		endcase
	end

	// Sequencer and per-item registers.
	pocp_pkg::state_t       state_q;
	logic                   ch_q;
	logic [SAMPLE_BITS-1:0] first_q, second_q;
	logic [PW-1:0]          p_q;
	logic [3:0]             cnt_q, k1_q;
	logic                   v1_q, v2_q;
	logic signed [31:0]     prod_q;
	logic signed [pocp_pkg::ACC_W-1:0] acc_q;
	logic signed [15:0]     filt_q, ac_q;
	logic [31:0]            dcn_q;

	// Per-channel and detector state.
	logic [PW-1:0]  pos_q [2];
	logic [31:0]    dc_q  [2];
	logic [11:0]    off_q [2];
	logic [11:0]    drv_q [2];
	logic [31:0]    en_q  [2];
	logic           pulse_q;
	logic [7:0]     deb_q;
	logic [3:0]     beat_q;
	logic [15:0]    scnt_q;
	logic [15:0]    win0_q;
	logic [31:0]    win1_q, win2_q;

	logic accept;
	assign smp.ready = (state_q == pocp_pkg::ST_IDLE);
	assign accept    = smp.valid && smp.ready;

	// Ring memory: written at accept, read twice per filter step.
	logic [AW-1:0]  raddr_a, raddr_b;
	logic [15:0]    rd_a, rd_b;

	assign raddr_a = {ch_q, p_q - PW'(cnt_q)};
	assign raddr_b = {ch_q, p_q - PW'(pocp_pkg::FIR_SPAN) + PW'(cnt_q)};

	pocp_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (accept),
		.waddr   ({smp.channel, pos_q[smp.channel]}),
		.wdata   (16'(smp.second_stage_sample)),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Filter pair sum wraps to 16 bits; the center tap stands alone.
	logic signed [15:0] pair;
	assign pair = (k1_q == 4'(pocp_pkg::CENTER_TAP)) ? $signed(rd_a) : $signed(rd_a + rd_b);

	// The shared multiplier takes tap products during the filter pass and the AC value
	// times itself in the square cycle.
	logic signed [15:0] mul_a, mul_b;
	always_comb begin
		if (state_q == pocp_pkg::ST_SQ) begin
			mul_a = ac_q;
			mul_b = ac_q;
		end else begin
			mul_a = pair;
			mul_b = $signed({1'b0, pocp_pkg::tap_coef(k1_q)});
		end
	end

	// DC tracker: cur + floor((filt*65536 - cur) / 512), kept to 32 bits.
	logic signed [15:0] filt_c;
	logic signed [48:0] diff_c;
	assign filt_c = acc_q[pocp_pkg::FIR_SHIFT +: 16];
	assign diff_c = {{17{filt_c[15]}}, filt_c, 16'd0} - {{17{dc_q[ch_q][31]}}, dc_q[ch_q]};

	// Update-cycle logic.
	logic [31:0]        en_new;
	logic [11:0]        off_new;
	logic signed [13:0] drv_ext, drv_tmp;
	logic [11:0]        drv_new;
	logic               edge_c, win_c, pulse_new;
	logic [7:0]         deb_new;
	logic [3:0]         beat_new, beat_inc;
	logic [15:0]        scnt_new, scnt_inc;
	logic [15:0]        first_ext, second_ext;

	always_comb begin
		first_ext  = 16'(first_q);
		second_ext = 16'(second_q);
		en_new     = en_q[ch_q] + {10'd0, prod_q[31:pocp_pkg::SQ_SHIFT]};

		// Offset nudge when the second stage sits at either rail.
		off_new = off_q[ch_q];
		if (second_q >= SAMPLE_MAX) begin
			if (off_q[ch_q] > pocp_pkg::OFFSET_MIN) begin
				off_new = off_q[ch_q] - 12'd1;
			end
		end else if (second_ext < pocp_pkg::RAIL_LOW) begin
			if (off_q[ch_q] < pocp_pkg::LEVEL_MAX) begin
				off_new = off_q[ch_q] + 12'd1;
			end
		end

		// LED drive with coarse and fine steps, clamped to the DAC range.
		drv_ext = $signed({2'b00, drv_q[ch_q]});
		drv_tmp = drv_ext;
		if (first_ext > 16'(target_high_q)) begin
			drv_tmp = drv_ext - (({3'd0, first_ext} >= {6'd0, coarse_high_q}) ? 14'sd5 : 14'sd1);
			if (drv_tmp < 14'sd0) begin
				drv_tmp = 14'sd0;
			end
		end else if (first_ext < 16'(target_low_q)) begin
			drv_tmp = drv_ext + ((first_ext < 16'(coarse_low_q)) ? 14'sd5 : 14'sd1);
			if (drv_tmp > 14'sd4095) begin
				drv_tmp = 14'sd4095;
			end
		end
		drv_new = drv_tmp[11:0];

		// Beat detector, infrared samples only.
		edge_c    = 1'b0;
		win_c     = 1'b0;
		pulse_new = pulse_q;
		deb_new   = deb_q;
		beat_new  = beat_q;
		beat_inc  = beat_q + 4'd1;
		scnt_inc  = scnt_q + 16'd1;
		scnt_new  = scnt_q;
		if (!ch_q) begin
			scnt_new = scnt_inc;
			if (deb_q < debounce_q) begin
				deb_new = deb_q + 8'd1;
			end else if (pulse_q) begin
				if (ac_q < fall_q) begin
					deb_new   = 8'd0;
					pulse_new = 1'b0;
					edge_c    = 1'b1;
				end
			end else if (ac_q > rise_q) begin
				deb_new   = 8'd0;
				pulse_new = 1'b1;
				edge_c    = 1'b1;
				beat_new  = beat_inc;
				if (beat_inc >= beats_q) begin
					win_c    = 1'b1;
					beat_new = 4'd0;
					scnt_new = 16'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= smp.channel;
			first_q  <= smp.first_stage_sample;
			second_q <= smp.second_stage_sample;
			p_q      <= pos_q[smp.channel];
		end
		k1_q   <= cnt_q;
		prod_q <= 32'(mul_a * mul_b);
		if (accept) begin
			acc_q <= '0;
		end else if (v2_q) begin
			acc_q <= acc_q + pocp_pkg::ACC_W'(prod_q);
		end
		if (state_q == pocp_pkg::ST_DC) begin
			filt_q <= filt_c;
			dcn_q  <= dc_q[ch_q] + diff_c[pocp_pkg::DC_SHIFT +: 32];
		end
		if (state_q == pocp_pkg::ST_AC) begin
			ac_q <= filt_q - $signed(dcn_q[31:16]);
		end
		if (state_q == pocp_pkg::ST_UPD) begin
			res.channel_out  <= ch_q;
			res.led_level    <= drv_new;
			res.amp_offset   <= off_new;
			res.ac_signal    <= ac_q;
			res.pulse_on     <= pulse_new;
			res.edge_seen    <= edge_c;
			res.window_valid <= win_c;
			res.window_samples    <= win_c ? scnt_inc : win0_q;
			res.window_ir_energy  <= win_c ? (ch_q ? en_q[0] : en_new) : win1_q;
			res.window_vis_energy <= win_c ? (ch_q ? en_new : en_q[1]) : win2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pocp_pkg::ST_IDLE;
			cnt_q    <= 4'd0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			dc_q[0]  <= '0;
			dc_q[1]  <= '0;
			off_q[0] <= pocp_pkg::OFFSET_RST;
			off_q[1] <= pocp_pkg::OFFSET_RST;
			drv_q[0] <= pocp_pkg::DRIVE_IR_RST;
			drv_q[1] <= pocp_pkg::DRIVE_VIS_RST;
			en_q[0]  <= '0;
			en_q[1]  <= '0;
			pulse_q  <= 1'b0;
			deb_q    <= '0;
			beat_q   <= '0;
			scnt_q   <= '0;
			win0_q   <= '0;
			win1_q   <= '0;
			win2_q   <= '0;
			res.valid <= 1'b0;
		end else begin
			v1_q <= (state_q == pocp_pkg::ST_FIR) && (cnt_q <= 4'(pocp_pkg::CENTER_TAP));
			v2_q <= v1_q;
			case (state_q)
				pocp_pkg::ST_IDLE: begin
					cnt_q <= 4'd0;
					if (accept) begin
						pos_q[smp.channel] <= pos_q[smp.channel] + PW'(1);
						state_q <= pocp_pkg::ST_FIR;
					end
				end
				pocp_pkg::ST_FIR: begin
					// Reads for twelve taps, then the read and product registers drain.
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(pocp_pkg::NUM_TAPS + 1)) begin
						state_q <= pocp_pkg::ST_DC;
					end
				end
				pocp_pkg::ST_DC: begin
					state_q <= pocp_pkg::ST_AC;
				end
				pocp_pkg::ST_AC: begin
					dc_q[ch_q] <= dcn_q;
					state_q    <= pocp_pkg::ST_SQ;
				end
				pocp_pkg::ST_SQ: begin
					state_q <= pocp_pkg::ST_UPD;
				end
				pocp_pkg::ST_UPD: begin
					off_q[ch_q] <= off_new;
					drv_q[ch_q] <= drv_new;
					pulse_q     <= pulse_new;
					deb_q       <= deb_new;
					beat_q      <= beat_new;
					scnt_q      <= scnt_new;
					if (win_c) begin
						// A new window takes both energies and restarts the sums.
						win0_q  <= scnt_inc;
						win1_q  <= ch_q ? en_q[0] : en_new;
						win2_q  <= ch_q ? en_new : en_q[1];
						en_q[0] <= '0;
						en_q[1] <= '0;
					end else begin
						en_q[ch_q] <= en_new;
					end
					res.valid <= 1'b1;
					state_q   <= pocp_pkg::ST_OUT;
				end
				pocp_pkg::ST_OUT: begin
					if (res.ready) begin
						res.valid <= 1'b0;
						state_q   <= pocp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pocp_pkg::ST_IDLE;
				end
			endcase
		end
	end
endmodule
